[src/afcd_pkg.sv]
// ----------------------------------------------------------------------------
// afcd_pkg: shared types and constants of the ASCII frame command decoder
// Frame marks, function code characters, command strings and result codes.
// ----------------------------------------------------------------------------
package afcd_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int LEN_W       = 7;
  localparam int NUM_CMDS    = 4;
  localparam int CMD_MAX_LEN = 10;
  localparam int TEXT_START  = 6;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t START_MARK = 8'h3A;
  localparam byte_t END_MARK   = 8'h0D;
  localparam byte_t NUL_CHAR   = 8'h00;
  localparam byte_t CHAR_0     = 8'h30;
  localparam byte_t CHAR_1     = 8'h31;
  localparam byte_t CHAR_2     = 8'h32;
  localparam byte_t STATION_RESET = 8'h33;

  localparam logic [CFG_INDEX_W-1:0] REG_STATION_HIGH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STATION_LOW  = 4'd1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SYSTEM  = 2'd1,
    ACT_OPERATE = 2'd2,
    ACT_CODE10  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    TXT_NONE        = 3'd0,
    TXT_RED_LED_ON  = 3'd1,
    TXT_RED_LED_OFF = 3'd2,
    TXT_GR_LED_ON   = 3'd3,
    TXT_GR_LED_OFF  = 3'd4
  } text_cmd_t;

  localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{4'd9, 4'd10, 4'd8, 4'd9};

  localparam byte_t CMD_TEXT [NUM_CMDS][CMD_MAX_LEN] = '{
    '{"r", "e", "d", " ", "l", "d", " ", "o", "n", " "},
    '{"r", "e", "d", " ", "l", "d", " ", "o", "f", "f"},
    '{"g", "r", " ", "l", "d", " ", "o", "n", " ", " "},
    '{"g", "r", " ", "l", "d", " ", "o", "f", "f", " "}
  };

endpackage

[src/afcd_if.sv]
// ----------------------------------------------------------------------------
// afcd channel interfaces
// Byte input, decode result and configuration write channels.
// ----------------------------------------------------------------------------
interface afcd_byte_if import afcd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afcd_result_if import afcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             address_match;
  logic [1:0]       action;
  logic [2:0]       text_command;
  logic [LEN_W-1:0] frame_length;
  modport source (output valid, output address_match, output action,
                  output text_command, output frame_length, input ready);
  modport sink   (input valid, input address_match, input action,
                  input text_command, input frame_length, output ready);
endinterface

interface afcd_cfg_if import afcd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  byte_t                  wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[src/ascii_frame_command_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ascii_frame_command_decoder_unit
// Receives a framed ASCII byte stream, decodes address, function code and
// command text, and reports one result per frame end.
// ----------------------------------------------------------------------------
// Timing: a byte is registered, then decoded in the next cycle; the result
//   of a CR that ends a frame is registered when that CR leaves the input register.
// Throughput: one byte per cycle, set by the single decode stage; a frame-end
//   CR waits in the input register while the previous result is unaccepted.
// Reset: synchronous, active high; position and latches clear, text flags set,
//   station address returns to "33", no result pending.
module ascii_frame_command_decoder_unit
  import afcd_pkg::*;
#(
  parameter int FRAME_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  afcd_byte_if.sink      rx,
  afcd_result_if.source  res,
  afcd_cfg_if.sink       cfg
);

  localparam int POS_W = $clog2(FRAME_DEPTH);
  localparam int KX_W  = POS_W + 4;
  localparam int PW_W  = POS_W + LEN_W;

  // configuration
  byte_t station_high;
  byte_t station_low;

  // input stage
  logic  s1_valid;
  byte_t s1_byte;

  // frame state
  logic [POS_W-1:0]     pos;
  byte_t                addr0, addr1, code0, code1;
  logic [NUM_CMDS-1:0]  flags;
  logic                 text_void;
  logic                 text_closed;

  logic [POS_W-1:0]     pos_next;
  byte_t                addr0_next, addr1_next, code0_next, code1_next;
  logic [NUM_CMDS-1:0]  flags_next;
  logic                 text_void_next;
  logic                 text_closed_next;

  // decode outputs
  logic             is_end;
  logic             s1_fire;
  logic             out_free;
  logic             am;
  action_t          act;
  text_cmd_t        tc;
  logic [LEN_W-1:0] flen;

  // working signals
  logic [POS_W-1:0]     pos_cur;
  logic [NUM_CMDS-1:0]  flags_base;
  logic                 void_base;
  logic                 closed_base;
  logic [KX_W-1:0]      kx;
  logic [3:0]           kl;
  logic [NUM_CMDS-1:0]  len_ok;
  logic [NUM_CMDS-1:0]  char_ok;
  logic [NUM_CMDS-1:0]  end_flags;
  logic [PW_W-1:0]      pos_wide;
  byte_t                a1_eff, c0_eff, c1_eff;

  assign out_free = !res.valid || res.ready;
  assign s1_fire  = s1_valid && (!is_end || out_free);
  assign rx.ready = !s1_valid || s1_fire;
  assign cfg.ready = 1'b1;

  always_comb begin
    pos_cur     = (s1_byte == START_MARK) ? '0 : pos;
    flags_base  = (s1_byte == START_MARK) ? '1 : flags;
    void_base   = (s1_byte == START_MARK) ? 1'b0 : text_void;
    closed_base = (s1_byte == START_MARK) ? 1'b0 : text_closed;

    is_end   = (s1_byte == END_MARK) && (pos_cur > POS_W'(1));
    kx       = KX_W'(pos_cur) - KX_W'(TEXT_START);
    kl       = kx[3:0];
    pos_wide = PW_W'(pos_cur);
    flen     = pos_wide[LEN_W-1:0];

    for (int i = 0; i < NUM_CMDS; i++) begin
      len_ok[i]  = (kx == KX_W'(CMD_LEN[i]));
      char_ok[i] = (kx < KX_W'(CMD_LEN[i])) && (CMD_TEXT[i][kl] == s1_byte);
    end

    // a CR in a short frame lands in its latch as zero
    a1_eff = (pos_cur == POS_W'(2)) ? '0 : addr1;
    c0_eff = (pos_cur == POS_W'(3)) ? '0 : code0;
    c1_eff = (pos_cur == POS_W'(4)) ? '0 : code1;

    if (pos_cur < POS_W'(TEXT_START)) begin
      end_flags = '0;
    end else if (!closed_base) begin
      end_flags = flags_base & len_ok;
    end else begin
      end_flags = flags_base;
    end

    am = (addr0 == station_high) && (a1_eff == station_low);
    act = ACT_NONE;
    if (am) begin
      priority if (c0_eff == CHAR_0 && c1_eff == CHAR_1) act = ACT_SYSTEM;
      else if (c0_eff == CHAR_0 && c1_eff == CHAR_2)     act = ACT_OPERATE;
      else if (c0_eff == CHAR_1 && c1_eff == CHAR_0)     act = ACT_CODE10;
      else                                               act = ACT_NONE;
    end

    tc = TXT_NONE;
    if (act == ACT_OPERATE && !void_base) begin
      priority if (end_flags[0]) tc = TXT_RED_LED_ON;
      else if (end_flags[1])     tc = TXT_RED_LED_OFF;
      else if (end_flags[2])     tc = TXT_GR_LED_ON;
      else if (end_flags[3])     tc = TXT_GR_LED_OFF;
      else                       tc = TXT_NONE;
    end

    addr0_next       = addr0;
    addr1_next       = addr1;
    code0_next       = code0;
    code1_next       = code1;
    flags_next       = flags_base;
    text_void_next   = void_base;
    text_closed_next = closed_base;
    pos_next         = pos_cur;

    if (is_end) begin
      addr1_next       = a1_eff;
      code0_next       = c0_eff;
      code1_next       = c1_eff;
      pos_next         = '0;
      flags_next       = '1;
      text_void_next   = 1'b0;
      text_closed_next = 1'b0;
    end else begin
      // position 0, position 5 and closed text store nothing
      if (pos_cur == POS_W'(1))      addr0_next = s1_byte;
      else if (pos_cur == POS_W'(2)) addr1_next = s1_byte;
      else if (pos_cur == POS_W'(3)) code0_next = s1_byte;
      else if (pos_cur == POS_W'(4)) code1_next = s1_byte;
      else if (pos_cur >= POS_W'(TEXT_START) && !closed_base) begin
        if (s1_byte == NUL_CHAR) begin
          // NUL closes the text at its current length
          flags_next       = flags_base & len_ok;
          text_closed_next = 1'b1;
        end else begin
          flags_next = flags_base & char_ok;
        end
      end

      if (pos_cur == POS_W'(FRAME_DEPTH - 1)) begin
        pos_next       = '0;
        text_void_next = 1'b1;
      end else begin
        pos_next = pos_cur + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_high <= STATION_RESET;
      station_low  <= STATION_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.reg_index == REG_STATION_HIGH) station_high <= cfg.wdata;
      if (cfg.reg_index == REG_STATION_LOW)  station_low  <= cfg.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) s1_byte <= rx.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      addr0       <= '0;
      addr1       <= '0;
      code0       <= '0;
      code1       <= '0;
      flags       <= '1;
      text_void   <= 1'b0;
      text_closed <= 1'b0;
    end else if (s1_fire) begin
      pos         <= pos_next;
      addr0       <= addr0_next;
      addr1       <= addr1_next;
      code0       <= code0_next;
      code1       <= code1_next;
      flags       <= flags_next;
      text_void   <= text_void_next;
      text_closed <= text_closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_fire && is_end) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && is_end) begin
      res.address_match <= am;
      res.action        <= act;
      res.text_command  <= tc;
      res.frame_length  <= flen;
    end
  end

endmodule

[tb/sv/ascii_frame_command_decoder_unit_test.sv]
// ----------------------------------------------------------------------------
// ascii_frame_command_decoder_unit_test: self-checking bench for the decoder
// Short table of hand-picked bytes, then framed random traffic under several
// station addresses. Each frame end is predicted in the bench and compared
// field by field with the result channel. Both sides throttle at random.
// ----------------------------------------------------------------------------
module ascii_frame_command_decoder_unit_test;
  import afcd_pkg::*;

  localparam int FRAME_DEPTH   = 64;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 5;
  localparam int PHASE_BYTES   = 200;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic             address_match;
    action_t          action;
    text_cmd_t        text_command;
    logic [LEN_W-1:0] frame_length;
  } frame_result_t;

  typedef struct packed {
    byte_t         b;
    bit            typed;
    frame_result_t r;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '{1'b0, ACT_NONE, TXT_NONE, '0};

  logic clk;
  logic rst;

  afcd_byte_if   rx_if ();
  afcd_result_if res_if ();
  afcd_cfg_if    cfg_if ();

  ascii_frame_command_decoder_unit #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // bench copy of the decoder state and station registers
  byte_t       station_high = STATION_RESET;
  byte_t       station_low  = STATION_RESET;
  int unsigned frame_pos    = 0;
  byte_t       addr_latch [2] = '{8'h00, 8'h00};
  byte_t       code_latch [2] = '{8'h00, 8'h00};
  logic [3:0]  text_flags   = 4'hF;
  bit          text_void    = 1'b0;
  bit          text_closed  = 1'b0;

  frame_result_t pending_results[$];
  int            errors       = 0;
  int            bytes_sent   = 0;
  int            cycle_count  = 0;
  bit            idle_on      = 1'b1;
  bit            long_hold_req = 1'b0;

  stim_row_t directed_rows [27] = '{
    '{END_MARK, 1'b0, NO_RESULT},                          // CR at 0 stores nothing
    '{END_MARK, 1'b0, NO_RESULT},                          // CR at 1 is stored
    '{END_MARK, 1'b1, '{1'b0, ACT_NONE, TXT_NONE, 7'd2}},
    '{START_MARK, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{END_MARK, 1'b1, '{1'b0, ACT_NONE, TXT_NONE, 7'd3}},
    '{START_MARK, 1'b0, NO_RESULT},
    '{STATION_RESET, 1'b0, NO_RESULT},
    '{STATION_RESET, 1'b0, NO_RESULT},
    '{CHAR_0, 1'b0, NO_RESULT},
    '{CHAR_1, 1'b0, NO_RESULT},
    '{END_MARK, 1'b1, '{1'b1, ACT_SYSTEM, TXT_NONE, 7'd5}},
    '{START_MARK, 1'b0, NO_RESULT},
    '{STATION_RESET, 1'b0, NO_RESULT},
    '{STATION_RESET, 1'b0, NO_RESULT},
    '{CHAR_1, 1'b0, NO_RESULT},
    '{CHAR_0, 1'b0, NO_RESULT},
    '{END_MARK, 1'b1, '{1'b1, ACT_CODE10, TXT_NONE, 7'd5}},
    '{START_MARK, 1'b0, NO_RESULT},
    '{STATION_RESET, 1'b0, NO_RESULT},
    '{STATION_RESET, 1'b0, NO_RESULT},
    '{CHAR_0, 1'b0, NO_RESULT},
    '{CHAR_2, 1'b0, NO_RESULT},
    '{"x", 1'b0, NO_RESULT},
    '{NUL_CHAR, 1'b0, NO_RESULT},                          // NUL closes empty text
    '{END_MARK, 1'b0, NO_RESULT}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_text_state();
    text_flags  = 4'hF;
    text_void   = 1'b0;
    text_closed = 1'b0;
  endfunction

  // only commands of exactly this length survive
  function automatic void close_text_flags(int unsigned len);
    for (int i = 0; i < NUM_CMDS; i++)
      if (CMD_LEN[i] != len) text_flags[i] = 1'b0;
    text_closed = 1'b1;
  endfunction

  function automatic bit decode_byte(input byte_t b, output frame_result_t r);
    int unsigned pos;
    int unsigned k;
    r = NO_RESULT;
    if (b == START_MARK) begin
      frame_pos = 0;
      clear_text_state();
    end
    pos = frame_pos;

    if (b == END_MARK && pos > 1) begin
      case (pos)
        2: addr_latch[1] = 8'h00;
        3: code_latch[0] = 8'h00;
        4: code_latch[1] = 8'h00;
        default: ;
      endcase
      if (pos < TEXT_START) text_flags = '0;
      else if (!text_closed) close_text_flags(pos - TEXT_START);

      r.address_match = (addr_latch[0] == station_high) && (addr_latch[1] == station_low);
      if (r.address_match) begin
        if (code_latch[0] == CHAR_0 && code_latch[1] == CHAR_1) r.action = ACT_SYSTEM;
        else if (code_latch[0] == CHAR_0 && code_latch[1] == CHAR_2) r.action = ACT_OPERATE;
        else if (code_latch[0] == CHAR_1 && code_latch[1] == CHAR_0) r.action = ACT_CODE10;
      end
      // walk down so the lowest surviving command wins
      if (r.action == ACT_OPERATE && !text_void)
        for (int i = NUM_CMDS - 1; i >= 0; i--)
          if (text_flags[i]) r.text_command = text_cmd_t'(i + 1);
      r.frame_length = pos[LEN_W-1:0];
      frame_pos = 0;
      clear_text_state();
      return 1'b1;
    end

    case (pos)
      1: addr_latch[0] = b;
      2: addr_latch[1] = b;
      3: code_latch[0] = b;
      4: code_latch[1] = b;
      default: begin
        if (pos >= TEXT_START && !text_closed) begin
          k = pos - TEXT_START;
          if (b == NUL_CHAR) close_text_flags(k);
          else
            for (int i = 0; i < NUM_CMDS; i++)
              if (k >= CMD_LEN[i] || CMD_TEXT[i][k] != b) text_flags[i] = 1'b0;
        end
      end
    endcase

    pos++;
    if (pos >= FRAME_DEPTH) begin
      pos = 0;
      text_void = 1'b1;
    end
    frame_pos = pos;
    return 1'b0;
  endfunction

  function automatic byte_t pick_frame_char();
    byte_t ch;
    do ch = byte_t'($urandom_range(8'h20, 8'h7E)); while (ch == START_MARK);
    return ch;
  endfunction

  // offer one byte; a typed expectation replaces the predicted one
  task automatic send_byte(input byte_t b, input bit typed, input frame_result_t typed_r);
    frame_result_t r;
    bit            has_result;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
    has_result = decode_byte(b, r);
    if (typed) pending_results.push_back(typed_r);
    else if (has_result) pending_results.push_back(r);
  endtask

  task automatic settle_block();
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_station(input byte_t hi, input byte_t lo);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= REG_STATION_HIGH;
    cfg_if.wdata     <= hi;
    do @(posedge clk); while (!cfg_if.ready);
    station_high = hi;
    cfg_if.reg_index <= REG_STATION_LOW;
    cfg_if.wdata     <= lo;
    do @(posedge clk); while (!cfg_if.ready);
    station_low = lo;
    cfg_if.valid <= 1'b0;
  endtask

  // kind: 0-64 well formed, 65-74 short, 75-79 long (may wrap), 80-87 no ':', rest noise
  task automatic send_random_frame();
    byte_t frame[$];
    int    kind;
    int    n;
    int    c;
    int    m;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      n = $urandom_range(1, 8);
      repeat (n) frame.push_back(byte_t'($urandom_range(0, 255)));
    end else if (kind >= 65 && kind < 75) begin
      frame.push_back(START_MARK);
      n = $urandom_range(0, 4);
      repeat (n) frame.push_back(pick_frame_char());
      frame.push_back(END_MARK);
    end else begin
      if (kind < 80) frame.push_back(START_MARK);
      c = $urandom_range(0, 19);
      frame.push_back((c == 0 || c == 2) ? pick_frame_char() : station_high);
      frame.push_back((c == 1 || c == 2) ? pick_frame_char() : station_low);
      c = $urandom_range(0, 9);
      case (c)
        0, 1: begin
          frame.push_back(CHAR_0);
          frame.push_back(CHAR_1);
        end
        6, 7: begin
          frame.push_back(CHAR_1);
          frame.push_back(CHAR_0);
        end
        8: begin
          frame.push_back(CHAR_1);
          frame.push_back(CHAR_1);
        end
        9: begin
          frame.push_back(pick_frame_char());
          frame.push_back(pick_frame_char());
        end
        default: begin
          frame.push_back(CHAR_0);
          frame.push_back(CHAR_2);
        end
      endcase
      frame.push_back(pick_frame_char());
      if (kind >= 75 && kind < 80) begin
        n = $urandom_range(50, 130);
        repeat (n) frame.push_back(pick_frame_char());
      end else begin
        c = $urandom_range(0, NUM_CMDS - 1);
        n = CMD_LEN[c];
        for (int k = 0; k < n; k++) frame.push_back(CMD_TEXT[c][k]);
        m = $urandom_range(0, 11);
        case (m)
          0: void'(frame.pop_back());
          1: frame.push_back(pick_frame_char());
          2: frame[frame.size() - 1 - $urandom_range(0, n - 1)] = pick_frame_char();
          3: begin
            frame.push_back(NUL_CHAR);
            repeat ($urandom_range(0, 3)) frame.push_back(pick_frame_char());
          end
          4: frame[frame.size() - 1 - $urandom_range(0, n - 1)] = NUL_CHAR;
          5: repeat (n) void'(frame.pop_back());
          default: ;
        endcase
      end
      frame.push_back(END_MARK);
    end
    foreach (frame[i]) send_byte(frame[i], 1'b0, NO_RESULT);
  endtask

  // result side: check, then pick next ready
  initial begin
    frame_result_t want;
    int            stall_left;
    stall_left   = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: no frame end pending");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (res_if.address_match !== want.address_match) begin
            $error("address_match: expected %0d, actual %0d",
                   want.address_match, res_if.address_match);
            errors++;
          end
          if (res_if.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, res_if.action);
            errors++;
          end
          if (res_if.text_command !== want.text_command) begin
            $error("text_command: expected %0d, actual %0d",
                   want.text_command, res_if.text_command);
            errors++;
          end
          if (res_if.frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, actual %0d",
                   want.frame_length, res_if.frame_length);
            errors++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
      res_if.ready <= (stall_left == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst              <= 1'b1;
    rx_if.valid      <= 1'b0;
    rx_if.rx_byte    <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= REG_STATION_HIGH;
    cfg_if.wdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].r);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      case (ph)
        1: write_station(8'h00, 8'hFF);
        2: write_station(8'hFF, 8'h00);
        3: write_station(pick_frame_char(), pick_frame_char());
        4: write_station(STATION_RESET, STATION_RESET);
        default: long_hold_req = 1'b1;  // sink holds off while bytes keep coming
      endcase
      idle_on = (ph != PHASES - 1);
      begin
        int phase_start;
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES) send_random_frame();
      end
    end

    settle_block();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[ascii_frame_command_decoder_unit.f]
src/afcd_pkg.sv
src/afcd_if.sv
src/ascii_frame_command_decoder_unit.sv
tb/sv/ascii_frame_command_decoder_unit_test.sv
